// File: design/tscu_pkg.sv
// Shared types, constants and the microcode program of the Taylor-series sine and cosine unit.
`default_nettype none

package tscu_pkg;

    // Number of series terms summed for every transaction.
    localparam int TERMS = 16;

    localparam int ANGLE_W = 32;
    localparam int VALUE_W = 32;

    // pi in Q8.24, rounded to nearest.
    localparam logic [ANGLE_W-1:0] PI_Q24 = 32'd52707179;

    // Range reduction: at most 2^31 / pi, so the quotient fits in six bits.
    localparam int RED_BITS = 6;
    localparam int K_W      = RED_BITS;

    // Reduced angle (Q.24, at most pi) and series term magnitude (Q.32, below 2^35).
    localparam int X_W    = 26;
    localparam int T_W    = 35;
    localparam int T_LO   = 17;
    localparam int FRAC_W = 24;
    localparam int P_W    = T_W + X_W;

    // Divider: eight quotient bits per iteration over a forty-bit shift register.
    localparam int DIV_BITS  = 8;
    localparam int DIV_ITERS = 5;
    localparam int Q_W       = DIV_BITS * DIV_ITERS;
    localparam int D_W       = $clog2(2 * TERMS + 1);

    localparam int TC_W  = $clog2(TERMS);
    localparam int SUM_W = 38;

    localparam logic [Q_W-1:0] ONE_Q32 = Q_W'(1) << 32;
    localparam int             ONE_Q30 = 1 << 30;

    // Sequencer widths.
    localparam int CNT_W = 3;
    localparam int PC_W  = 4;

    localparam logic [CNT_W-1:0] RED_CNT_INIT = CNT_W'(RED_BITS - 1);
    localparam logic [CNT_W-1:0] DIV_CNT_INIT = CNT_W'(DIV_ITERS - 1);

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_RED_INIT,
        OP_RED_STEP,
        OP_SER_INIT,
        OP_ACC,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_DIV_STEP,
        OP_FINISH
    } dp_op_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_WAIT_IN,
        COND_LOOP,
        COND_LAST,
        COND_WAIT_OUT
    } cond_t;

    typedef struct packed {
        dp_op_t            op;
        cond_t             cond;
        logic              load_cnt;
        logic [CNT_W-1:0]  cnt_init;
        logic [PC_W-1:0]   target;
    } uword_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        dp_op_t            op;
        logic              go;
        logic [CNT_W-1:0]  cnt;
    } ctrl_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic last_term;
    } status_t;

    localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
    localparam logic [PC_W-1:0] PC_RED_INIT = 4'd1;
    localparam logic [PC_W-1:0] PC_RED_STEP = 4'd2;
    localparam logic [PC_W-1:0] PC_SER_INIT = 4'd3;
    localparam logic [PC_W-1:0] PC_ACC      = 4'd4;
    localparam logic [PC_W-1:0] PC_MUL_LO_A = 4'd5;
    localparam logic [PC_W-1:0] PC_MUL_HI_A = 4'd6;
    localparam logic [PC_W-1:0] PC_DIV_A    = 4'd7;
    localparam logic [PC_W-1:0] PC_MUL_LO_B = 4'd8;
    localparam logic [PC_W-1:0] PC_MUL_HI_B = 4'd9;
    localparam logic [PC_W-1:0] PC_DIV_B    = 4'd10;
    localparam logic [PC_W-1:0] PC_FINISH   = 4'd11;

    function automatic uword_t make_word(input dp_op_t op, input cond_t cond,
                                         input logic load_cnt,
                                         input logic [CNT_W-1:0] cnt_init,
                                         input logic [PC_W-1:0] target);
        uword_t w;
        w.op       = op;
        w.cond     = cond;
        w.load_cnt = load_cnt;
        w.cnt_init = cnt_init;
        w.target   = target;
        return w;
    endfunction

    // The program: one control word per step.
    function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            PC_IDLE:     w = make_word(OP_LOAD, COND_WAIT_IN, 1'b0, '0, PC_RED_INIT);
            PC_RED_INIT: w = make_word(OP_RED_INIT, COND_ALWAYS, 1'b1, RED_CNT_INIT,
                                       PC_RED_STEP);
            PC_RED_STEP: w = make_word(OP_RED_STEP, COND_LOOP, 1'b0, '0, PC_SER_INIT);
            PC_SER_INIT: w = make_word(OP_SER_INIT, COND_ALWAYS, 1'b0, '0, PC_ACC);
            PC_ACC:      w = make_word(OP_ACC, COND_LAST, 1'b0, '0, PC_FINISH);
            PC_MUL_LO_A: w = make_word(OP_MUL_LO, COND_ALWAYS, 1'b0, '0, PC_MUL_HI_A);
            PC_MUL_HI_A: w = make_word(OP_MUL_HI, COND_ALWAYS, 1'b1, DIV_CNT_INIT,
                                       PC_DIV_A);
            PC_DIV_A:    w = make_word(OP_DIV_STEP, COND_LOOP, 1'b0, '0, PC_MUL_LO_B);
            PC_MUL_LO_B: w = make_word(OP_MUL_LO, COND_ALWAYS, 1'b0, '0, PC_MUL_HI_B);
            PC_MUL_HI_B: w = make_word(OP_MUL_HI, COND_ALWAYS, 1'b1, DIV_CNT_INIT,
                                       PC_DIV_B);
            PC_DIV_B:    w = make_word(OP_DIV_STEP, COND_LOOP, 1'b0, '0, PC_ACC);
            PC_FINISH:   w = make_word(OP_FINISH, COND_WAIT_OUT, 1'b0, '0, PC_IDLE);
            default:     w = make_word(OP_NOP, COND_ALWAYS, 1'b0, '0, PC_IDLE);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: design/tscu_sequencer.sv
// Microcode sequencer: step counter, loop counter and program table.
`default_nettype none

module tscu_sequencer (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire logic              out_busy,
    input  wire tscu_pkg::status_t stat,
    output tscu_pkg::ctrl_t        ctrl
);

    logic [tscu_pkg::PC_W-1:0]  pc_reg;
    logic [tscu_pkg::PC_W-1:0]  pc_next;
    logic [tscu_pkg::CNT_W-1:0] cnt_reg;
    logic [tscu_pkg::CNT_W-1:0] cnt_next;
    tscu_pkg::uword_t           uw;
    logic                       go;

    assign uw = tscu_pkg::ucode_rom(pc_reg);

    always_comb begin
        pc_next  = pc_reg;
        cnt_next = cnt_reg;
        go       = 1'b1;
        case (uw.cond)
            tscu_pkg::COND_WAIT_IN: begin
                go = in_valid;
                if (in_valid) begin
                    pc_next = uw.target;
                end
            end
            tscu_pkg::COND_LOOP: begin
                if (cnt_reg != '0) begin
                    cnt_next = cnt_reg - tscu_pkg::CNT_W'(1);
                end else begin
                    pc_next = uw.target;
                end
            end
            tscu_pkg::COND_LAST: begin
                pc_next = stat.last_term ? uw.target : pc_reg + tscu_pkg::PC_W'(1);
            end
            tscu_pkg::COND_WAIT_OUT: begin
                go = !out_busy;
                if (!out_busy) begin
                    pc_next = uw.target;
                end
            end
            default: begin
                pc_next = uw.target;
            end
        endcase
        if (go && uw.load_cnt) begin
            cnt_next = uw.cnt_init;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg  <= tscu_pkg::PC_IDLE;
            cnt_reg <= '0;
        end else begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

    assign ctrl.op  = uw.op;
    assign ctrl.go  = go;
    assign ctrl.cnt = cnt_reg;

endmodule

`default_nettype wire

// File: design/tscu_datapath.sv
// Datapath: range reduction, shared multiplier, radix-256 divider and series accumulator.
`default_nettype none

module tscu_datapath (
    input  wire logic                          aclk,
    input  wire tscu_pkg::ctrl_t               ctrl,
    input  wire logic                          operation,
    input  wire logic [tscu_pkg::ANGLE_W-1:0]  angle,
    output tscu_pkg::status_t                  stat,
    output logic      [tscu_pkg::VALUE_W-1:0]  value
);

    localparam int PL_W = tscu_pkg::T_LO + tscu_pkg::X_W;
    localparam int PH_W = tscu_pkg::T_W - tscu_pkg::T_LO + tscu_pkg::X_W;
    localparam int RND_W = tscu_pkg::SUM_W - 2;

    logic                          cos_reg;
    logic                          neg_reg;
    logic                          big_reg;
    logic [tscu_pkg::ANGLE_W-1:0]  rem_reg;
    logic [tscu_pkg::K_W-1:0]      k_reg;
    logic [tscu_pkg::X_W-1:0]      x_reg;
    logic [tscu_pkg::Q_W-1:0]      tq_reg;
    logic [tscu_pkg::P_W-1:0]      p_reg;
    logic [tscu_pkg::D_W-1:0]      drem_reg;
    logic [tscu_pkg::D_W-1:0]      d_reg;
    logic [tscu_pkg::SUM_W-1:0]    sum_reg;
    logic                          sub_reg;
    logic [tscu_pkg::TC_W-1:0]     term_cnt_reg;

    logic [tscu_pkg::ANGLE_W-1:0]  mag_in;
    logic [tscu_pkg::ANGLE_W-1:0]  pi_sh;
    logic                          red_hit;
    logic [tscu_pkg::ANGLE_W-1:0]  x_calc;
    logic [tscu_pkg::T_W-1:0]      t_cur;
    logic [tscu_pkg::SUM_W-1:0]    t_ext;
    logic [tscu_pkg::SUM_W-1:0]    sum_acc;
    logic [PL_W-1:0]               prod_lo;
    logic [PH_W-1:0]               prod_hi;
    logic [tscu_pkg::P_W-1:0]      p_sum;
    logic [tscu_pkg::D_W-1:0]      div_r;
    logic [tscu_pkg::Q_W-1:0]      div_q;
    logic [tscu_pkg::SUM_W-1:0]    sum_mag;
    logic [tscu_pkg::SUM_W-1:0]    sum_rnd;
    logic [RND_W-1:0]              rnd;
    logic [30:0]                   sat;
    logic                          out_neg;

    assign mag_in  = angle[tscu_pkg::ANGLE_W-1] ? (~angle + 32'd1) : angle;
    assign pi_sh   = tscu_pkg::PI_Q24 << ctrl.cnt;
    assign red_hit = big_reg && (rem_reg >= pi_sh);
    assign x_calc  = big_reg ? rem_reg + 32'd1 : rem_reg;

    assign t_cur   = tq_reg[tscu_pkg::T_W-1:0];
    assign t_ext   = {{(tscu_pkg::SUM_W - tscu_pkg::T_W){1'b0}}, t_cur};
    assign sum_acc = sub_reg ? sum_reg - t_ext : sum_reg + t_ext;

    assign prod_lo = t_cur[tscu_pkg::T_LO-1:0] * x_reg;
    assign prod_hi = t_cur[tscu_pkg::T_W-1:tscu_pkg::T_LO] * x_reg;
    assign p_sum   = p_reg + {prod_hi, {tscu_pkg::T_LO{1'b0}}};

    // Eight restoring division steps on the narrow remainder.
    always_comb begin
        logic [tscu_pkg::D_W:0] r2;
        div_r = drem_reg;
        div_q = tq_reg;
        for (int j = 0; j < tscu_pkg::DIV_BITS; j++) begin
            r2    = {div_r, div_q[tscu_pkg::Q_W-1]};
            div_q = {div_q[tscu_pkg::Q_W-2:0], 1'b0};
            if (r2 >= {1'b0, d_reg}) begin
                r2       = r2 - {1'b0, d_reg};
                div_q[0] = 1'b1;
            end
            div_r = r2[tscu_pkg::D_W-1:0];
        end
    end

    // Round the magnitude to Q1.30, saturate and apply the quadrant sign.
    assign sum_mag = sum_reg[tscu_pkg::SUM_W-1] ? (~sum_reg + tscu_pkg::SUM_W'(1)) : sum_reg;
    assign sum_rnd = sum_mag + tscu_pkg::SUM_W'(2);
    assign rnd     = sum_rnd[tscu_pkg::SUM_W-1:2];
    assign sat     = (rnd > RND_W'(tscu_pkg::ONE_Q30)) ? 31'(tscu_pkg::ONE_Q30) : rnd[30:0];
    assign out_neg = sum_reg[tscu_pkg::SUM_W-1] ^ k_reg[0] ^ (!cos_reg && neg_reg);
    assign value   = out_neg ? (~{1'b0, sat} + 32'd1) : {1'b0, sat};

    assign stat.last_term = (term_cnt_reg == '0);

    always_ff @(posedge aclk) begin
        if (ctrl.go) begin
            case (ctrl.op)
                tscu_pkg::OP_LOAD: begin
                    cos_reg <= operation;
                    neg_reg <= angle[tscu_pkg::ANGLE_W-1];
                    rem_reg <= mag_in;
                end
                tscu_pkg::OP_RED_INIT: begin
                    big_reg <= rem_reg > tscu_pkg::PI_Q24;
                    rem_reg <= (rem_reg > tscu_pkg::PI_Q24) ? rem_reg - 32'd1 : rem_reg;
                    k_reg   <= '0;
                end
                tscu_pkg::OP_RED_STEP: begin
                    if (red_hit) begin
                        rem_reg          <= rem_reg - pi_sh;
                        k_reg[ctrl.cnt]  <= 1'b1;
                    end
                end
                tscu_pkg::OP_SER_INIT: begin
                    x_reg        <= x_calc[tscu_pkg::X_W-1:0];
                    tq_reg       <= cos_reg ? tscu_pkg::ONE_Q32
                                            : {{(tscu_pkg::Q_W - tscu_pkg::X_W - 8){1'b0}},
                                               x_calc[tscu_pkg::X_W-1:0], 8'd0};
                    d_reg        <= {{(tscu_pkg::D_W - 1){1'b0}}, !cos_reg};
                    sum_reg      <= '0;
                    sub_reg      <= 1'b0;
                    term_cnt_reg <= tscu_pkg::TC_W'(tscu_pkg::TERMS - 1);
                end
                tscu_pkg::OP_ACC: begin
                    sum_reg <= sum_acc;
                    sub_reg <= !sub_reg;
                    if (term_cnt_reg != '0) begin
                        term_cnt_reg <= term_cnt_reg - tscu_pkg::TC_W'(1);
                    end
                end
                tscu_pkg::OP_MUL_LO: begin
                    p_reg <= tscu_pkg::P_W'(prod_lo);
                    d_reg <= d_reg + tscu_pkg::D_W'(1);
                end
                tscu_pkg::OP_MUL_HI: begin
                    tq_reg   <= tscu_pkg::Q_W'(p_sum[tscu_pkg::P_W-1:tscu_pkg::FRAC_W]);
                    drem_reg <= '0;
                end
                tscu_pkg::OP_DIV_STEP: begin
                    tq_reg   <= div_q;
                    drem_reg <= div_r;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/taylor_sine_cosine_unit.sv
// Top level of the Taylor-series sine and cosine unit with its stream ports and result register.
// Each series term: an accumulate step, then two multiply and divide passes on the shared units.
// Reset (aresetn low at a rising edge) returns the step counter to idle and empties the result
// register; no arithmetic state needs clearing.
`default_nettype none

module taylor_sine_cosine_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] angle, signed Q8.24 radians
    input  wire logic [0:0]  s_tuser,   // [0] operation: 0 sine, 1 cosine

    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata    // [31:0] value, signed Q1.30
);

    tscu_pkg::ctrl_t   ctrl;
    tscu_pkg::status_t stat;
    logic [tscu_pkg::VALUE_W-1:0] value;

    logic                          m_tvalid_reg;
    logic                          m_tvalid_next;
    logic [tscu_pkg::VALUE_W-1:0]  m_tdata_reg;
    logic                          out_busy;
    logic                          out_load;

    // The result register frees the datapath: the sequencer returns to idle and takes the
    // next transaction while a finished result still waits for the downstream side.
    assign out_busy = m_tvalid_reg && !m_tready;
    assign out_load = ctrl.go && (ctrl.op == tscu_pkg::OP_FINISH);

    // The input side is ready only while the sequencer sits on its idle step.
    assign s_tready = (ctrl.op == tscu_pkg::OP_LOAD);

    tscu_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .out_busy (out_busy),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    tscu_datapath u_dp (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .operation (s_tuser[0]),
        .angle     (s_tdata),
        .stat      (stat),
        .value     (value)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        if (out_load) begin
            m_tdata_reg <= value;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// File: verif/taylor_sine_cosine_unit_checker.sv
// Checker for the Taylor-series sine and cosine unit: watches both streams and predicts every result.
module taylor_sine_cosine_unit_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic [0:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    output int               failures,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] expected_values[$];
    int          fail_total = 0;

    // Q1.30 sine or cosine of a Q8.24 angle: reduction by pi, a truncated series, then rounding.
    function automatic logic [31:0] taylor_value(input logic is_cosine, input logic [31:0] angle);
        logic        negative;
        logic        sneg;
        logic        flip;
        logic [63:0] mag;
        logic [63:0] turns;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] power;
        logic [63:0] smag;
        longint      sum;
        negative = angle[31];
        mag      = negative ? (64'h1_0000_0000 - {32'd0, angle}) : {32'd0, angle};
        turns    = 64'd0;
        if (mag > 64'(tscu_pkg::PI_Q24)) begin
            turns = (mag - 64'd1) / 64'(tscu_pkg::PI_Q24);
        end
        x     = mag - turns * 64'(tscu_pkg::PI_Q24);
        term  = is_cosine ? (64'd1 << 32) : (x << 8);
        power = is_cosine ? 64'd0 : 64'd1;
        sum   = 0;
        for (int i = 0; i < tscu_pkg::TERMS; i++) begin
            if (i % 2 == 0) begin
                sum += longint'(term);
            end else begin
                sum -= longint'(term);
            end
            term  = (term * x) / ((power + 64'd1) << 24);
            term  = (term * x) / ((power + 64'd2) << 24);
            power = power + 64'd2;
        end
        sneg = sum < 0;
        smag = sneg ? unsigned'(-sum) : unsigned'(sum);
        smag = (smag + 64'd2) >> 2;
        if (smag > 64'h4000_0000) begin
            smag = 64'h4000_0000;
        end
        flip = turns[0];
        if (!is_cosine && negative) begin
            flip = !flip;
        end
        if (flip) begin
            sneg = !sneg;
        end
        return sneg ? (32'd0 - smag[31:0]) : smag[31:0];
    endfunction

    always @(posedge aclk) begin
        logic [31:0] want;
        if (aresetn) begin
            // A result can never belong to the input taken at the same edge, so pop first.
            if (m_tvalid && m_tready) begin
                if (expected_values.size() == 0) begin
                    $display("%0t: result 0x%08h arrived with nothing expected", $time, m_tdata);
                    fail_total++;
                end else begin
                    want = expected_values.pop_front();
                    if (m_tdata !== want) begin
                        $display("%0t: value mismatch, expected 0x%08h, actual 0x%08h",
                                 $time, want, m_tdata);
                        fail_total++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_values.push_back(taylor_value(s_tuser[0], s_tdata));
            end
        end
        failures    <= fail_total;
        outstanding <= expected_values.size();
    end

endmodule

// File: verif/taylor_sine_cosine_unit_test.sv
// Top of the testbench for the Taylor-series sine and cosine unit: stimulus and verdict.
module taylor_sine_cosine_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Operation codes carried in tuser.
    localparam logic SEL_SINE   = 1'b0;
    localparam logic SEL_COSINE = 1'b1;

    // Number of random transactions after the directed ones.
    localparam int RANDOM_ITEMS = 1026;

    // Margin waited after the last outstanding result; it covers the tail.
    localparam int DRAIN_CYCLES = 400;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    int          failures;
    int          outstanding;

    // Remaining transactions of a stretch that is sent without any idle cycles.
    int          steady_left = 0;

    always #5 aclk = ~aclk;

    taylor_sine_cosine_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    taylor_sine_cosine_unit_checker checker_inst (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .failures    (failures),
        .outstanding (outstanding)
    );

    // Idle length between transactions: mostly none or short, now and then a long one. Long
    // gaps can exceed the block's working time, so the next transaction lands in every phase.
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            return 0;
        end else if (roll < 88) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 60);
        end
        return $urandom_range(61, 300);
    endfunction

    // Random Q8.24 angle. Whole-range words exercise every bit; the other shapes crowd around
    // the places where the reduction and the sign handling change behaviour.
    function automatic logic [31:0] random_angle();
        int roll;
        int mag;
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            return $urandom();
        end else if (roll < 70) begin
            mag = $urandom_range(0, 4 * tscu_pkg::PI_Q24);
        end else if (roll < 90) begin
            // Close to a whole number of half turns, including the exact multiples.
            mag = $urandom_range(0, 40) * tscu_pkg::PI_Q24 + $urandom_range(0, 6) - 3;
        end else begin
            // Close to a whole multiple of pi/2, where the result passes through zero or one.
            mag = ($urandom_range(0, 80) * tscu_pkg::PI_Q24 + tscu_pkg::PI_Q24) / 2
                  + $urandom_range(0, 8) - 4;
        end
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // Offers one transaction after a random pause and holds it until the block takes it.
    // Entered just after a rising edge, so each step sees at most one update of s_tvalid.
    task automatic send_angle(input logic op, input logic [31:0] angle);
        int gap;
        if (steady_left > 0) begin
            steady_left--;
            gap = 0;
        end else begin
            gap = idle_length();
            if ($urandom_range(0, 99) < 3) begin
                steady_left = $urandom_range(20, 60);
            end
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= angle;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Result side: ready for random stretches, stalled for random stretches. Occasional long
    // ready stretches give runs of results taken without back-pressure.
    initial begin
        forever begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < 10) begin
                repeat ($urandom_range(500, 3000)) @(posedge aclk);
            end else begin
                repeat ($urandom_range(1, 40)) @(posedge aclk);
            end
            m_tready <= 1'b0;
            if ($urandom_range(0, 99) < 90) begin
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                repeat ($urandom_range(5, 400)) @(posedge aclk);
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        logic [31:0] corner_angles[12];
        corner_angles = '{
            32'd0, 32'd1, 32'hFFFF_FFFF,
            tscu_pkg::PI_Q24, tscu_pkg::PI_Q24 + 32'd1, 32'd0 - tscu_pkg::PI_Q24,
            2 * tscu_pkg::PI_Q24, 3 * tscu_pkg::PI_Q24,
            32'h7FFF_FFFF, 32'h8000_0000,
            tscu_pkg::PI_Q24 / 2, 32'd0 - tscu_pkg::PI_Q24 / 2
        };
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= SEL_SINE;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: zero, the smallest steps either side of it, exact multiples of pi
        // (where the reduction stops at pi), the largest angle, the most negative angle and
        // plus and minus pi/2. Every angle goes through both sine and cosine, which also shows
        // that the angle's sign does not reach the cosine.
        foreach (corner_angles[i]) begin
            send_angle(SEL_SINE, corner_angles[i]);
            send_angle(SEL_COSINE, corner_angles[i]);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            send_angle($urandom_range(0, 1) ? SEL_COSINE : SEL_SINE, random_angle());
        end
        s_tvalid <= 1'b0;

        // The checker's count of outstanding results includes the last transaction only from
        // the next edge on. Wait for every outstanding result, then let the block sit idle for
        // a while to catch any result that should not appear.
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: many times the slowest correct run, with every transaction meeting the longest
    // pause on the input side and the longest stall on the result side.
    initial begin
        #50ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
